FILE: rtl/figure_block_store_responder_top_defines.svh
// Assertion macros shared by the figure block store responder checks
`ifndef FIGURE_BLOCK_STORE_RESPONDER_TOP_DEFINES_SVH
`define FIGURE_BLOCK_STORE_RESPONDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fsr_pkg.sv
// Types, codes and constants of the figure block store responder
package fsr_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CMD    = 2'd2;
  localparam logic [1:0] KIND_POLL   = 2'd3;

  // Command and report codes (ASCII)
  localparam logic [7:0] CODE_QUERY  = 8'h51;
  localparam logic [7:0] CODE_WRITE  = 8'h57;
  localparam logic [7:0] CODE_STATUS = 8'h53;

  // Minimum command lengths
  localparam logic [6:0] QUERY_MIN_LEN = 7'd3;
  localparam logic [6:0] WRITE_MIN_LEN = 7'd19;

  // Store geometry
  localparam int NUM_BLOCKS_DEF = 64;
  localparam int IDX_W          = 8;
  localparam int BLOCK_W        = 128;
  localparam int UID_W          = 32;

  // Request from the control logic to the block store
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [BLOCK_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
  } mem_req_t;

  // Registered read response from the block store
  typedef struct packed {
    logic [BLOCK_W-1:0] data;
    logic               valid;
  } mem_rsp_t;

endpackage

FILE: rtl/fsr_if.sv
// Valid/ready channel interfaces for input items and report items
interface fsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  cmd_code;
  logic [6:0]  cmd_len;
  logic [7:0]  block_index;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic        load_last;

  modport source (output valid, kind, cmd_code, cmd_len, block_index, data_hi, data_lo,
                  load_last, input ready);
  modport sink (input valid, kind, cmd_code, cmd_len, block_index, data_hi, data_lo,
                load_last, output ready);
endinterface

interface fsr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  report_code;
  logic        status_byte;
  logic [7:0]  index_byte;
  logic [63:0] payload_hi;
  logic [63:0] payload_lo;

  modport source (output valid, report_code, status_byte, index_byte, payload_hi,
                  payload_lo, input ready);
  modport sink (input valid, report_code, status_byte, index_byte, payload_hi,
                payload_lo, output ready);
endinterface

FILE: rtl/fsr_store.sv
// Block store: one write port, one registered read port, per-entry valid bits
module fsr_store #(
  parameter int NUM_BLOCKS = fsr_pkg::NUM_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fsr_pkg::mem_req_t req,
  output fsr_pkg::mem_rsp_t rsp
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [fsr_pkg::BLOCK_W-1:0] mem_r [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]       vld_r;
  logic [fsr_pkg::BLOCK_W-1:0] rd_data_r;
  logic                        rd_vld_r;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  assign wr_addr = req.wr_idx[AW-1:0];
  assign rd_addr = req.rd_idx[AW-1:0];

  // Memory array write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Entry valid bits; an entry never written reads back with valid low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rsp.data  = rd_data_r;
  assign rsp.valid = rd_vld_r;

endmodule

FILE: rtl/figure_block_store_responder_top.sv
// Top level of the figure block store responder
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    kind cmd_code cmd_len block_index data_hi data_lo load_last
//  out_ch   out  valid/ready    report_code status_byte index_byte payload_hi payload_lo
//
// Load, remove and command items are taken back to back.
// A poll moves the sequencer to the send state: the block store read is registered,
// and in_ch.ready is low while the report is formed.
// Reset is synchronous; the store's valid bits all clear together, no sweep.
// A report waits in the output register; non-poll items keep flowing, and a
// poll stays in the send state until the output register is free.
module figure_block_store_responder_top #(
  parameter int NUM_BLOCKS = fsr_pkg::NUM_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fsr_in_if.sink           in_ch,
  fsr_out_if.source        out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  fsr_pkg::mem_req_t mem_req;
  fsr_pkg::mem_rsp_t mem_rsp;

  logic [fsr_pkg::UID_W-1:0] uid_r, uid_nxt;
  logic [fsr_pkg::UID_W-1:0] blk0_uid_r, blk0_uid_nxt;
  logic                      present_r, present_nxt;
  logic                      qwait_r, qwait_nxt;
  logic [7:0]                qblk_r, qblk_nxt;

  // Pending report fields, captured when a poll is taken
  logic                      pend_ans_r;
  logic                      pend_inrng_r;
  logic [7:0]                pend_idx_r;
  logic                      pend_present_r;
  logic [fsr_pkg::UID_W-1:0] pend_uid_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_code_r;
  logic        out_status_r;
  logic [7:0]  out_index_r;
  logic [63:0] out_hi_r;
  logic [63:0] out_lo_r;

  logic accept;
  logic is_load, is_remove, is_cmd, is_poll;
  logic idx_in_range, qblk_in_range;
  logic wr_cmd_ok, query_cmd_ok;
  logic answer;
  logic out_free;
  logic send_fire;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_load   = accept && (in_ch.kind == fsr_pkg::KIND_LOAD);
  assign is_remove = accept && (in_ch.kind == fsr_pkg::KIND_REMOVE);
  assign is_cmd    = accept && (in_ch.kind == fsr_pkg::KIND_CMD);
  assign is_poll   = accept && (in_ch.kind == fsr_pkg::KIND_POLL);

  assign idx_in_range  = {1'b0, in_ch.block_index} < 9'(NUM_BLOCKS);
  assign qblk_in_range = {1'b0, qblk_r} < 9'(NUM_BLOCKS);

  // Command decode; a zero length fails both minimum-length checks
  assign query_cmd_ok = (in_ch.cmd_code == fsr_pkg::CODE_QUERY) &&
                        (in_ch.cmd_len >= fsr_pkg::QUERY_MIN_LEN);
  assign wr_cmd_ok    = (in_ch.cmd_code == fsr_pkg::CODE_WRITE) &&
                        (in_ch.cmd_len >= fsr_pkg::WRITE_MIN_LEN) && present_r;

  assign answer = qwait_r && present_r;

  // Block store requests
  assign mem_req.wr_en   = (is_load || (is_cmd && wr_cmd_ok)) && idx_in_range;
  assign mem_req.wr_idx  = in_ch.block_index;
  assign mem_req.wr_data = {in_ch.data_hi, in_ch.data_lo};
  assign mem_req.rd_en   = is_poll && answer && qblk_in_range;
  assign mem_req.rd_idx  = qblk_r;

  fsr_store #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .rsp  (mem_rsp)
  );

  // Figure and query state
  always_comb begin
    blk0_uid_nxt = blk0_uid_r;
    uid_nxt      = uid_r;
    present_nxt  = present_r;
    qwait_nxt    = qwait_r;
    qblk_nxt     = qblk_r;
    if (mem_req.wr_en && (in_ch.block_index == 8'd0)) begin
      blk0_uid_nxt = in_ch.data_hi[63:32];
    end
    if (is_load && in_ch.load_last) begin
      uid_nxt     = blk0_uid_nxt;
      present_nxt = 1'b1;
    end
    if (is_remove) begin
      uid_nxt     = '0;
      present_nxt = 1'b0;
    end
    if (is_cmd && query_cmd_ok) begin
      qblk_nxt  = in_ch.block_index;
      qwait_nxt = 1'b1;
    end
    if (is_poll && answer) begin
      qwait_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk0_uid_r <= '0;
      uid_r      <= '0;
      present_r  <= 1'b0;
      qwait_r    <= 1'b0;
      qblk_r     <= '0;
    end else begin
      blk0_uid_r <= blk0_uid_nxt;
      uid_r      <= uid_nxt;
      present_r  <= present_nxt;
      qwait_r    <= qwait_nxt;
      qblk_r     <= qblk_nxt;
    end
  end

  // Poll capture
  always_ff @(posedge clk) begin
    if (is_poll) begin
      pend_ans_r     <= answer;
      pend_inrng_r   <= qblk_in_range;
      pend_idx_r     <= qblk_r;
      pend_present_r <= present_r;
      pend_uid_r     <= uid_r;
    end
  end

  // Sequencer
  assign out_free  = !out_valid_r || out_ch.ready;
  assign send_fire = (state_r == ST_SEND) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (is_poll) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (send_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (send_fire) begin
      if (pend_ans_r) begin
        out_code_r   <= fsr_pkg::CODE_QUERY;
        out_status_r <= 1'b0;
        out_index_r  <= pend_idx_r;
        if (pend_inrng_r && mem_rsp.valid) begin
          out_hi_r <= mem_rsp.data[127:64];
          out_lo_r <= mem_rsp.data[63:0];
        end else begin
          out_hi_r <= '0;
          out_lo_r <= '0;
        end
      end else begin
        out_code_r   <= fsr_pkg::CODE_STATUS;
        out_status_r <= pend_present_r;
        out_index_r  <= '0;
        out_hi_r     <= pend_present_r ? {8'h00, pend_uid_r, 24'h000000} : 64'h0;
        out_lo_r     <= '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.report_code = out_code_r;
  assign out_ch.status_byte = out_status_r;
  assign out_ch.index_byte  = out_index_r;
  assign out_ch.payload_hi  = out_hi_r;
  assign out_ch.payload_lo  = out_lo_r;

endmodule

FILE: rtl/fsr_checker.sv
// Port-level checks on the figure block store responder, bound to the top level
`include "figure_block_store_responder_top_defines.svh"

module fsr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_report_code,
  input logic       out_status_byte
);

  logic in_take;
  logic poll_take;

  assign in_take   = in_valid && in_ready;
  assign poll_take = in_take && (in_kind == fsr_pkg::KIND_POLL);

  // A stalled report stays offered
  `FSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "report dropped while stalled")

  // A poll closes the input for the report cycle
  `FSR_ASSERT_NEXT(a_poll_blocks, poll_take, !in_ready, "input open right after a poll")

  // Non-poll items never block the next one
  `FSR_ASSERT_NEXT(a_flow_on, in_take && !poll_take, in_ready, "input closed after a non-poll item")

  // A report appearing on an empty output follows a poll, through the send state
  `FSR_ASSERT_NOW(a_report_src, $rose(out_valid), $past(poll_take, 2), "report without poll")

  // A query answer carries no status flag
  `FSR_ASSERT_NOW(a_query_status, out_valid && (out_report_code == fsr_pkg::CODE_QUERY),
                  !out_status_byte, "status flag set in query answer")

endmodule

bind figure_block_store_responder_top fsr_checker u_fsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_kind        (in_ch.kind),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_report_code(out_ch.report_code),
  .out_status_byte(out_ch.status_byte)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for figure_block_store_responder_top: directed and random items, report scoreboard
module testbench;

  localparam int NBLK         = fsr_pkg::NUM_BLOCKS_DEF;
  localparam int NBLK_AW      = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    bit [1:0]  kind;
    bit [7:0]  cmd_code;
    bit [6:0]  cmd_len;
    bit [7:0]  block_index;
    bit [63:0] data_hi;
    bit [63:0] data_lo;
    bit        load_last;
    bit        drain_first;  // sender holds this item until no report is outstanding
  } host_item_t;

  typedef struct {
    bit [7:0]  code;
    bit        status;
    bit [7:0]  index;
    bit [63:0] hi;
    bit [63:0] lo;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fsr_in_if  in_ch ();
  fsr_out_if out_ch ();

  figure_block_store_responder_top #(
    .NUM_BLOCKS(NBLK)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5ns clk = ~clk;

  // Stimulus and expected reports
  host_item_t item_q[$];
  report_t    report_q[$];
  bit         drain_next;
  int         total_items;
  int         accepted_items;
  int         pending_reports;
  int         err_count;
  int         idle_cycles;

  // Shadow state of the reader
  bit [127:0] blk_mem [NBLK];
  bit [31:0]  fig_uid;
  bit         fig_present;
  bit         qry_pending;
  bit [7:0]   qry_idx;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Apply one accepted item to the shadow state; a poll queues its report
  function automatic void predict_report(input host_item_t it);
    report_t r;
    r = '{default: 0};
    case (it.kind)
      fsr_pkg::KIND_LOAD: begin
        if (it.block_index < NBLK)
          blk_mem[it.block_index[NBLK_AW-1:0]] = {it.data_hi, it.data_lo};
        if (it.load_last) begin
          fig_uid     = blk_mem[0][127:96];
          fig_present = 1'b1;
        end
      end
      fsr_pkg::KIND_REMOVE: begin
        fig_present = 1'b0;
        fig_uid     = '0;
      end
      fsr_pkg::KIND_CMD: begin
        if (it.cmd_len != 0) begin
          if (it.cmd_code == fsr_pkg::CODE_QUERY) begin
            if (it.cmd_len >= fsr_pkg::QUERY_MIN_LEN) begin
              qry_idx     = it.block_index;
              qry_pending = 1'b1;
            end
          end else if (it.cmd_code == fsr_pkg::CODE_WRITE) begin
            if (it.cmd_len >= fsr_pkg::WRITE_MIN_LEN && fig_present && it.block_index < NBLK)
              blk_mem[it.block_index[NBLK_AW-1:0]] = {it.data_hi, it.data_lo};
          end
        end
      end
      default: begin
        if (qry_pending && fig_present) begin
          r.code  = fsr_pkg::CODE_QUERY;
          r.index = qry_idx;
          if (qry_idx < NBLK) {r.hi, r.lo} = blk_mem[qry_idx[NBLK_AW-1:0]];
          qry_pending = 1'b0;
        end else begin
          r.code   = fsr_pkg::CODE_STATUS;
          r.status = fig_present;
          r.hi     = fig_present ? {8'h00, fig_uid, 24'h000000} : 64'h0;
        end
        report_q.push_back(r);
      end
    endcase
  endfunction

  // Per-item wait, with occasional stretches of no idling at all
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 63) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic bit [63:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly valid block numbers, some past the end of the store
  function automatic bit [7:0] pick_index();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(NBLK, 255));
    return 8'($urandom_range(0, NBLK - 1));
  endfunction

  function automatic bit [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic bit [6:0] rand_len();
    return 7'($urandom_range(0, 64));
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void add_item(input bit [1:0] kind, input bit [7:0] code,
                                   input bit [6:0] len, input bit [7:0] idx,
                                   input bit [63:0] hi, input bit [63:0] lo,
                                   input bit last);
    host_item_t it;
    it.kind        = kind;
    it.cmd_code    = code;
    it.cmd_len     = len;
    it.block_index = idx;
    it.data_hi     = hi;
    it.data_lo     = lo;
    it.load_last   = last;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    item_q.push_back(it);
  endfunction

  // Driver: presents queued items, idling between them
  int unsigned tx_wait;
  bit          tx_quiet;

  always @(posedge clk) begin
    host_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait     <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (tx_wait != 0) begin
        in_ch.valid <= 1'b0;
        tx_wait     <= tx_wait - 1;
      end else if (item_q.size() != 0 &&
                   (!item_q[0].drain_first || (!in_ch.valid && pending_reports == 0))) begin
        nxt                = item_q.pop_front();
        in_ch.kind        <= nxt.kind;
        in_ch.cmd_code    <= nxt.cmd_code;
        in_ch.cmd_len     <= nxt.cmd_len;
        in_ch.block_index <= nxt.block_index;
        in_ch.data_hi     <= nxt.data_hi;
        in_ch.data_lo     <= nxt.data_lo;
        in_ch.load_last   <= nxt.load_last;
        in_ch.valid       <= 1'b1;
        tx_wait           <= draw_wait(tx_quiet);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted items, checks accepted reports, stalls ready
  int unsigned rx_wait;
  bit          rx_quiet;

  always @(posedge clk) begin
    host_item_t  seen;
    report_t     want;
    int unsigned stall;
    if (!rst_n) begin
      out_ch.ready    <= 1'b0;
      rx_wait         <= 0;
      pending_reports <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.kind        = in_ch.kind;
        seen.cmd_code    = in_ch.cmd_code;
        seen.cmd_len     = in_ch.cmd_len;
        seen.block_index = in_ch.block_index;
        seen.data_hi     = in_ch.data_hi;
        seen.data_lo     = in_ch.data_lo;
        seen.load_last   = in_ch.load_last;
        seen.drain_first = 1'b0;
        predict_report(seen);
        accepted_items++;
      end
      stall = rx_wait;
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          note_mismatch("report with none expected, code", 64'(out_ch.report_code), '0);
        end else begin
          want = report_q.pop_front();
          if (out_ch.report_code !== want.code)
            note_mismatch("report_code", 64'(out_ch.report_code), 64'(want.code));
          if (out_ch.status_byte !== want.status)
            note_mismatch("status_byte", 64'(out_ch.status_byte), 64'(want.status));
          if (out_ch.index_byte !== want.index)
            note_mismatch("index_byte", 64'(out_ch.index_byte), 64'(want.index));
          if (out_ch.payload_hi !== want.hi)
            note_mismatch("payload_hi", out_ch.payload_hi, want.hi);
          if (out_ch.payload_lo !== want.lo)
            note_mismatch("payload_lo", out_ch.payload_lo, want.lo);
        end
        stall = draw_wait(rx_quiet);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        rx_wait      <= stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        rx_wait      <= 0;
      end
      pending_reports <= report_q.size();
    end
  end

  // Cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL figure_block_store_responder_top");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    int n_dir;
    int cnt;
    bit [7:0] idx;

    in_ch.valid       = 1'b0;
    in_ch.kind        = fsr_pkg::KIND_LOAD;
    in_ch.cmd_code    = '0;
    in_ch.cmd_len     = '0;
    in_ch.block_index = '0;
    in_ch.data_hi     = '0;
    in_ch.data_lo     = '0;
    in_ch.load_last   = 1'b0;
    out_ch.ready      = 1'b0;

    // No figure: status with zero identifier; a query stays pending
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY, fsr_pkg::QUERY_MIN_LEN, 8'd5, '1, '1,
             1'b1);
    add_item(fsr_pkg::KIND_POLL, 8'hff, 7'd64, 8'hff, '1, '1, 1'b1);
    // Write with no figure is dropped
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE, fsr_pkg::WRITE_MIN_LEN, 8'd2, '1, '1,
             1'b0);
    add_item(fsr_pkg::KIND_LOAD, 8'h00, 7'd0, 8'd0, 64'h0123_4567_89ab_cdef,
             64'hfedc_ba98_7654_3210, 1'b0);
    add_item(fsr_pkg::KIND_LOAD, 8'hff, 7'd64, 8'd63, '1, '1, 1'b0);
    // Out-of-range load marked last: stores nothing, figure still comes up
    add_item(fsr_pkg::KIND_LOAD, 8'hff, 7'd64, 8'hff, '1, '1, 1'b1);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    // Short query ignored, then status with identifier
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY, fsr_pkg::QUERY_MIN_LEN - 7'd1, 8'd63,
             '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY, 7'd64, 8'd63, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    // Short, good, out-of-range and empty writes, then an unknown code
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE, fsr_pkg::WRITE_MIN_LEN - 7'd1, 8'd1,
             '1, '1, 1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE, fsr_pkg::WRITE_MIN_LEN, 8'd1,
             64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE, fsr_pkg::WRITE_MIN_LEN, 8'd64, '1, '1,
             1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE, 7'd0, 8'd1, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_CMD, 8'h00, 7'd64, 8'd1, '1, '1, 1'b0);
    // Query past the end answers zeros
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY, fsr_pkg::QUERY_MIN_LEN, 8'hff, '0, '0,
             1'b0);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY, fsr_pkg::QUERY_MIN_LEN, 8'd1, '0, '0,
             1'b0);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    // Reload block 0 while present, after all reports are in
    drain_next = 1'b1;
    add_item(fsr_pkg::KIND_LOAD, 8'h00, 7'd0, 8'd0, 64'hdead_beef_0bad_f00d, '0, 1'b1);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    // Remove keeps the query; it is answered once a figure returns
    add_item(fsr_pkg::KIND_REMOVE, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY, fsr_pkg::QUERY_MIN_LEN, 8'd0, '0, '0,
             1'b0);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    add_item(fsr_pkg::KIND_LOAD, 8'h00, 7'd0, 8'd3, rand_data(), rand_data(), 1'b1);
    add_item(fsr_pkg::KIND_POLL, 8'h00, 7'd0, 8'd0, '0, '0, 1'b0);
    n_dir = item_q.size();

    // Random part: mostly well-formed sequences, some noise
    drain_next = 1'b1;
    while (item_q.size() < n_dir + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          cnt = $urandom_range(1, 4);
          for (int k = 0; k < cnt; k++) begin
            idx = (k == 0 && $urandom_range(0, 1)) ? 8'd0 : pick_index();
            add_item(fsr_pkg::KIND_LOAD, rand_byte(), rand_len(), idx, rand_data(),
                     rand_data(), k == cnt - 1);
          end
        end
        1: add_item(fsr_pkg::KIND_REMOVE, rand_byte(), rand_len(), rand_byte(), rand_data(),
                    rand_data(), rand_bit());
        2, 3: begin
          add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY,
                   7'($urandom_range(fsr_pkg::QUERY_MIN_LEN, 64)), pick_index(),
                   rand_data(), rand_data(), rand_bit());
          add_item(fsr_pkg::KIND_POLL, rand_byte(), rand_len(), rand_byte(), rand_data(),
                   rand_data(), rand_bit());
          if ($urandom_range(0, 3) == 0)
            add_item(fsr_pkg::KIND_POLL, rand_byte(), rand_len(), rand_byte(), rand_data(),
                     rand_data(), rand_bit());
        end
        4, 5: begin
          idx = pick_index();
          add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE,
                   7'($urandom_range(fsr_pkg::WRITE_MIN_LEN, 64)), idx, rand_data(),
                   rand_data(), rand_bit());
          add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY,
                   7'($urandom_range(fsr_pkg::QUERY_MIN_LEN, 64)), idx, rand_data(),
                   rand_data(), rand_bit());
          add_item(fsr_pkg::KIND_POLL, rand_byte(), rand_len(), rand_byte(), rand_data(),
                   rand_data(), rand_bit());
        end
        6: add_item(fsr_pkg::KIND_POLL, rand_byte(), rand_len(), rand_byte(), rand_data(),
                    rand_data(), rand_bit());
        7: begin
          // short commands and unknown codes
          case ($urandom_range(0, 2))
            0: add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_QUERY,
                        7'($urandom_range(0, fsr_pkg::QUERY_MIN_LEN - 7'd1)),
                        pick_index(), rand_data(), rand_data(), rand_bit());
            1: add_item(fsr_pkg::KIND_CMD, fsr_pkg::CODE_WRITE,
                        7'($urandom_range(0, fsr_pkg::WRITE_MIN_LEN - 7'd1)),
                        pick_index(), rand_data(), rand_data(), rand_bit());
            default: add_item(fsr_pkg::KIND_CMD, rand_byte(), rand_len(), rand_byte(),
                              rand_data(), rand_data(), rand_bit());
          endcase
        end
        default: add_item(2'($urandom_range(0, 3)), rand_byte(), rand_len(), rand_byte(),
                          rand_data(), rand_data(), rand_bit());
      endcase
    end
    total_items = item_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every report to arrive
    while (accepted_items < total_items || report_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("PASS figure_block_store_responder_top");
    else
      $display("FAIL figure_block_store_responder_top");
    $finish;
  end

endmodule
